[hw/rtl/ltfw_pkg.sv]
// Shared types and codes for the lock table with first-in-first-out waiters.
package ltfw_pkg;

	// Request codes carried in the command field; any other code acts as a query.
	localparam logic [1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_POP
	} ltfw_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;    // capture the request and read its lock entry
		logic pop_rd;   // read the oldest waiter of the addressed lock
		logic commit;   // write the updated lock entry and load the result
		logic pop_sel;  // the update is a handoff to the fetched waiter
	} ltfw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_pop;  // release on a lock that has waiters
		logic out_free;  // the result register can take a new item
	} ltfw_stat_t;

endpackage

[hw/rtl/ltfw_ctrl.sv]
// Controller state machine that sequences one lock request at a time.
module ltfw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ltfw_pkg::ltfw_stat_t stat,
	output ltfw_pkg::ltfw_cmd_t  ctl
);
	import ltfw_pkg::*;

	ltfw_state_t state_q;
	ltfw_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (stat.need_pop) begin
					state_d = ST_POP;
				end else if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready    = 1'b0;
		ctl.latch   = 1'b0;
		ctl.pop_rd  = 1'b0;
		ctl.commit  = 1'b0;
		ctl.pop_sel = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctl.latch = in_valid;
			end
			ST_LOOK: begin
				ctl.pop_rd = stat.need_pop;
				ctl.commit = !stat.need_pop && stat.out_free;
			end
			ST_POP: begin
				ctl.pop_sel = 1'b1;
				ctl.commit  = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[hw/rtl/ltfw_datapath.sv]
// Datapath: lock table, waiter store, update logic and the result register.
module ltfw_datapath #(
	parameter int LOCK_COUNT  = 16,
	parameter int QUEUE_DEPTH = 8,
	parameter int ID_BITS     = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ltfw_pkg::ltfw_cmd_t  ctl,
	output ltfw_pkg::ltfw_stat_t stat,
	input  logic [1:0]           command,
	input  logic [3:0]           lock_index,
	input  logic [7:0]           requester_id,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          out_data
);
	import ltfw_pkg::*;

	localparam int LiW    = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
	localparam int HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int SW     = CW + 1;
	localparam int Slots  = LOCK_COUNT * QUEUE_DEPTH;
	localparam int AW     = (Slots > 1) ? $clog2(Slots) : 1;

	// Lock table and waiter store; the valid bits make unwritten lock entries read as free.
	logic          lk_held_mem  [LOCK_COUNT];
	logic [ID_BITS-1:0] lk_owner_mem [LOCK_COUNT];
	logic [HW-1:0] lk_head_mem  [LOCK_COUNT];
	logic [CW-1:0] lk_count_mem [LOCK_COUNT];
	logic [LOCK_COUNT-1:0] lk_valid_q;
	logic [ID_BITS-1:0] wt_mem [Slots];

	// Captured request and entry read data.
	logic [1:0]         cmd_q;
	logic [LiW-1:0]     li_q;
	logic               in_range_q;
	logic [ID_BITS-1:0] rid_q;
	logic               ent_valid_q;
	logic               ent_held_q;
	logic [ID_BITS-1:0] ent_owner_q;
	logic [HW-1:0]      ent_head_q;
	logic [CW-1:0]      ent_count_q;
	logic [ID_BITS-1:0] wt_rd_q;

	// Result register.
	logic        out_valid_q;
	logic [15:0] out_data_q;

	logic [LiW-1:0] li_in;
	logic           in_range_in;
	logic               cur_held;
	logic [ID_BITS-1:0] cur_owner;
	logic [HW-1:0]      cur_head;
	logic [CW-1:0]      cur_count;
	logic [SW-1:0]      tail_sum;
	logic [HW-1:0]      tail_slot;
	logic [CW-1:0]      head_inc;
	logic [HW-1:0]      head_next;
	logic [AW-1:0]      wt_waddr;
	logic [AW-1:0]      wt_raddr;
	logic               wt_we;
	logic               nxt_held;
	logic [ID_BITS-1:0] nxt_owner;
	logic [HW-1:0]      nxt_head;
	logic [CW-1:0]      nxt_count;
	logic               res_granted;
	logic               res_full;
	logic               push;
	logic               lk_we;

	assign li_in       = LiW'(lock_index);
	assign in_range_in = (int'(lock_index) < LOCK_COUNT);

	// Request capture and lock entry read.
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q      <= command;
			li_q       <= li_in;
			in_range_q <= in_range_in;
			rid_q      <= ID_BITS'(requester_id);
			if (in_range_in) begin
				ent_held_q  <= lk_held_mem[li_in];
				ent_owner_q <= lk_owner_mem[li_in];
				ent_head_q  <= lk_head_mem[li_in];
				ent_count_q <= lk_count_mem[li_in];
			end
		end
		if (lk_we) begin
			lk_held_mem[li_q]  <= nxt_held;
			lk_owner_mem[li_q] <= nxt_owner;
			lk_head_mem[li_q]  <= nxt_head;
			lk_count_mem[li_q] <= nxt_count;
		end
	end

	// Entry valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_valid_q  <= '0;
			ent_valid_q <= 1'b0;
		end else begin
			if (ctl.latch) begin
				ent_valid_q <= in_range_in && lk_valid_q[li_in];
			end
			if (lk_we) begin
				lk_valid_q[li_q] <= 1'b1;
			end
		end
	end

	// Entry as seen by the update logic; an unwritten entry is a free lock.
	assign cur_held  = ent_valid_q && ent_held_q;
	assign cur_owner = ent_valid_q ? ent_owner_q : '0;
	assign cur_head  = ent_valid_q ? ent_head_q : '0;
	assign cur_count = ent_valid_q ? ent_count_q : '0;

	// Circular queue positions: tail slot for a push, next head after a pop.
	assign tail_sum  = SW'(cur_head) + SW'(cur_count);
	assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
	                                                 : HW'(tail_sum);
	assign head_inc  = CW'(cur_head) + CW'(1);
	assign head_next = (head_inc >= CW'(QUEUE_DEPTH)) ? HW'(head_inc - CW'(QUEUE_DEPTH))
	                                                 : HW'(head_inc);

	assign wt_waddr = AW'(int'(li_q) * QUEUE_DEPTH + int'(tail_slot));
	assign wt_raddr = AW'(int'(li_q) * QUEUE_DEPTH + int'(cur_head));

	// Next lock entry and result flags.
	always_comb begin
		nxt_held    = cur_held;
		nxt_owner   = cur_owner;
		nxt_head    = cur_head;
		nxt_count   = cur_count;
		res_granted = 1'b0;
		res_full    = 1'b0;
		push        = 1'b0;
		case (cmd_q)
			CMD_ACQUIRE: begin
				if (!cur_held) begin
					nxt_held    = 1'b1;
					nxt_owner   = rid_q;
					res_granted = 1'b1;
				end else if (cur_count == CW'(QUEUE_DEPTH)) begin
					res_full = 1'b1;
				end else begin
					push      = 1'b1;
					nxt_count = cur_count + CW'(1);
				end
			end
			CMD_RELEASE: begin
				if (ctl.pop_sel) begin
					nxt_held  = 1'b1;
					nxt_owner = wt_rd_q;
					nxt_head  = head_next;
					nxt_count = cur_count - CW'(1);
				end else begin
					nxt_held  = 1'b0;
					nxt_owner = '0;
				end
			end
			default: begin
				// Query and the unused code leave the entry as it is.
				nxt_held = cur_held;
			end
		endcase
	end

	assign lk_we = ctl.commit && in_range_q;
	assign wt_we = lk_we && push;

	// Waiter store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_waddr] <= rid_q;
		end
		if (ctl.pop_rd) begin
			wt_rd_q <= wt_mem[wt_raddr];
		end
	end

	// Result register, loaded on commit and emptied when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			if (in_range_q) begin
				out_data_q <= {1'b0, res_full, 4'(nxt_count),
				               (nxt_held ? 8'(nxt_owner) : 8'd0), nxt_held, res_granted};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.need_pop  = in_range_q && (cmd_q == CMD_RELEASE) && (cur_count != '0);

endmodule

[hw/rtl/lock_table_with_fifo_waiters_unit.sv]
// Top level of the lock table with first-in-first-out waiter queues.
//
// Requests enter on the s_axis channel: acquire, release or query of one lock.
// Each request yields exactly one result item on the m_axis channel with the
// grant flag, the owner after the operation, the waiter count and a flag that
// marks an acquire dropped because the lock's wait queue was full.
// Requests are handled one at a time by a small sequencer. An acquire, a query
// or a release with no waiters is loaded into the result register from the look
// step; a release that hands the lock to a waiter is loaded from the pop step,
// since the waiter store is read through its registered port after the lock entry.
// A new request is accepted in the cycle after the previous result is loaded,
// and a waiting result does not hold up the input side.
// If the receiver stalls, the result register holds its item and the next
// request waits in the commit step until the register is free.
// Reset clears all locks to free with empty queues at once, through one valid
// bit per lock entry; the waiter store needs no clearing.
module lock_table_with_fifo_waiters_unit #(
	parameter int LOCK_COUNT  = 16,
	parameter int QUEUE_DEPTH = 8,
	parameter int ID_BITS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[1:0], lock_index[5:2], requester_id[13:6], zero[15:14]
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// granted[0], has_owner[1], owner_id[9:2], waiter_count[13:10], queue_full[14], zero[15]
	output logic [15:0] m_axis_tdata
);
	import ltfw_pkg::*;

	ltfw_cmd_t  ctl;
	ltfw_stat_t stat;

	ltfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	ltfw_datapath #(
		.LOCK_COUNT  (LOCK_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.command      (s_axis_tdata[1:0]),
		.lock_index   (s_axis_tdata[5:2]),
		.requester_id (s_axis_tdata[13:6]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata)
	);

	// A result is never loaded over one that the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten");

	// After an accepted item the block is not ready again in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while the previous one is in work");

	// A waiter read is always followed by the handoff step, not by a new item.
	a_pop_then_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop_rd |=> (ctl.pop_sel && !s_axis_tready))
		else $error("waiter read without handoff");

	// A granted acquire leaves the lock held and is never also a dropped one.
	a_grant_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[1] && !m_axis_tdata[14]))
		else $error("inconsistent grant result");

endmodule
